// ===== rtl/r2q_pkg.sv =====
// shared constants, record type and output saturation for the rotation matrix to
// quaternion block
// no dependencies
package r2q_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 18;
  localparam int NUM_IN    = 9;
  localparam int NUM_COMP  = 4;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((NUM_IN * IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_COMP * OUT_W + 7) / 8) * 8;

  localparam longint ONE_VAL = longint'(1) << FRAC_BITS;
  localparam longint OUT_MAX = 131071;

  // vector component magnitude, signed working width, squares and length
  localparam int MAG_W = $clog2(ONE_VAL + 3 * 131072);
  localparam int RAD_W = MAG_W + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int LEN_W = SQ_W + 2;

  // quotient bits of a2 * 2^(2F+2) / len2, root bits of its square root
  localparam int DIV_N = 2 * FRAC_BITS + 3;
  localparam int SQ_N  = FRAC_BITS + 2;
  localparam int QP_W  = 2 * SQ_N;
  localparam int RR_W  = SQ_N + 3;

  // queue between front and back
  localparam int QUEUE_D = 4;
  localparam int QPTR_W  = $clog2(QUEUE_D);
  localparam int QCNT_W  = $clog2(QUEUE_D + 1);

  // back pipeline depth up to the output register
  localparam int BACK_LAT = 3 + DIV_N + SQ_N;

  // identity scalar part, saturated
  localparam logic [OUT_W-1:0] IDENT_W = (ONE_VAL > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(ONE_VAL);

  // classified item: fallback flag, signs and magnitudes of (w, x, y, z) vector
  typedef struct packed {
    logic                               fb;
    logic [NUM_COMP-1:0]                neg;
    logic [NUM_COMP-1:0][MAG_W-1:0]     mag;
  } rec_t;

  // saturate a rounded magnitude and apply its sign
  function automatic logic [OUT_W-1:0] sat_out(input logic [SQ_N-1:0] n, input logic neg);
    longint nv;
    nv = longint'(n);
    if (nv > OUT_MAX) nv = OUT_MAX;
    if (neg) nv = -nv;
    return nv[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/r2q_front.sv =====
// front classifier: picks the branch, forms the unscaled vector and flags fallback
// depends on r2q_pkg
module r2q_front (
  input  logic [r2q_pkg::IN_TDATA_W-1:0] in_data,
  output r2q_pkg::rec_t                  rec
);

  logic signed [r2q_pkg::IN_W-1:0]  m [r2q_pkg::NUM_IN];
  logic signed [r2q_pkg::RAD_W-1:0] e [r2q_pkg::NUM_IN];
  logic signed [r2q_pkg::RAD_W-1:0] one_s, trace, rad;
  logic signed [r2q_pkg::RAD_W-1:0] d_x, d_y, d_z, s01, s02, s12;
  logic signed [r2q_pkg::RAD_W-1:0] v [r2q_pkg::NUM_COMP];

  // unpack and sign extend the matrix entries
  always_comb begin
    for (int i = 0; i < r2q_pkg::NUM_IN; i++) begin
      m[i] = in_data[i*r2q_pkg::IN_W +: r2q_pkg::IN_W];
      e[i] = r2q_pkg::RAD_W'(m[i]);
    end
  end

  // sums and differences of off-diagonal entries
  assign one_s = r2q_pkg::RAD_W'(r2q_pkg::ONE_VAL);
  assign trace = e[0] + e[4] + e[8];
  assign d_x   = e[7] - e[5];
  assign d_y   = e[2] - e[6];
  assign d_z   = e[3] - e[1];
  assign s01   = e[1] + e[3];
  assign s02   = e[2] + e[6];
  assign s12   = e[5] + e[7];

  // branch select, ties go to the later diagonal entry
  always_comb begin
    if (trace > 0) begin
      rad  = one_s + trace;
      v[0] = rad; v[1] = d_x; v[2] = d_y; v[3] = d_z;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      rad  = one_s + e[0] - e[4] - e[8];
      v[0] = d_x; v[1] = rad; v[2] = s01; v[3] = s02;
    end else if (e[4] > e[8]) begin
      rad  = one_s + e[4] - e[0] - e[8];
      v[0] = d_y; v[1] = s01; v[2] = rad; v[3] = s12;
    end else begin
      rad  = one_s + e[8] - e[0] - e[4];
      v[0] = d_z; v[1] = s02; v[2] = s12; v[3] = rad;
    end
  end

  // split into sign and magnitude
  always_comb begin
    rec.fb = (rad <= 0);
    for (int i = 0; i < r2q_pkg::NUM_COMP; i++) begin
      rec.neg[i] = v[i][r2q_pkg::RAD_W-1];
      rec.mag[i] = r2q_pkg::MAG_W'(v[i][r2q_pkg::RAD_W-1] ? -v[i] : v[i]);
    end
  end

endmodule

// ===== rtl/r2q_queue.sv =====
// short queue of classified items between the front and the back
// depends on r2q_pkg
module r2q_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  r2q_pkg::rec_t wr_rec,
  output logic          full,
  input  logic          pop,
  output r2q_pkg::rec_t rd_rec,
  output logic          not_empty
);

  r2q_pkg::rec_t               mem_r [r2q_pkg::QUEUE_D];
  logic [r2q_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [r2q_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == r2q_pkg::QCNT_W'(r2q_pkg::QUEUE_D));
  assign not_empty = (cnt_r != '0);
  assign rd_rec    = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == r2q_pkg::QPTR_W'(r2q_pkg::QUEUE_D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == r2q_pkg::QPTR_W'(r2q_pkg::QUEUE_D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_rec;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= r2q_pkg::QCNT_W'(r2q_pkg::QUEUE_D))
    else $error("queue fill count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");

endmodule

// ===== rtl/r2q_lane.sv =====
// one normalising lane: restoring divide of a^2 * 2^(2F+2) by the squared length,
// then a digit-by-digit square root, one step per stage; depends on r2q_pkg
module r2q_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [r2q_pkg::SQ_W-1:0]     a2,
  input  logic [r2q_pkg::LEN_W-1:0]    len2,
  input  logic                         neg_i,
  output logic [r2q_pkg::SQ_N-1:0]     n_o,
  output logic                         neg_o
);

  localparam int DN = r2q_pkg::DIV_N;
  localparam int SN = r2q_pkg::SQ_N;

  logic [r2q_pkg::LEN_W-1:0] rem_r [DN];
  logic [r2q_pkg::LEN_W-1:0] rem_nxt [DN];
  logic [r2q_pkg::LEN_W-1:0] den_r [DN];
  logic [DN-1:0]             quo_r [DN];
  logic [DN-1:0]             quo_nxt [DN];
  logic                      dneg_r [DN];

  logic [r2q_pkg::RR_W-1:0]  srem_r [SN];
  logic [r2q_pkg::RR_W-1:0]  srem_nxt [SN];
  logic [SN-1:0]             root_r [SN];
  logic [SN-1:0]             root_nxt [SN];
  logic [r2q_pkg::QP_W-1:0]  srad_r [SN];
  logic [r2q_pkg::QP_W-1:0]  srad_nxt [SN];
  logic                      sneg_r [SN];

  // divider steps, integer bit first
  always_comb begin
    logic [r2q_pkg::LEN_W:0] tr;
    logic [r2q_pkg::LEN_W:0] dd;
    tr = {1'b0, r2q_pkg::LEN_W'(a2)};
    dd = {1'b0, len2};
    if (tr >= dd) begin
      rem_nxt[0] = r2q_pkg::LEN_W'(tr - dd);
      quo_nxt[0] = DN'(1);
    end else begin
      rem_nxt[0] = r2q_pkg::LEN_W'(tr);
      quo_nxt[0] = '0;
    end
    for (int k = 1; k < DN; k++) begin
      tr = {rem_r[k-1], 1'b0};
      dd = {1'b0, den_r[k-1]};
      if (tr >= dd) begin
        rem_nxt[k] = r2q_pkg::LEN_W'(tr - dd);
        quo_nxt[k] = {quo_r[k-1][DN-2:0], 1'b1};
      end else begin
        rem_nxt[k] = r2q_pkg::LEN_W'(tr);
        quo_nxt[k] = {quo_r[k-1][DN-2:0], 1'b0};
      end
    end
  end

  // square root steps, two radicand bits per stage
  always_comb begin
    logic [r2q_pkg::RR_W-1:0] prem, r2, trial;
    logic [SN-1:0]            proot;
    logic [r2q_pkg::QP_W-1:0] prad;
    for (int j = 0; j < SN; j++) begin
      if (j == 0) begin
        prem  = '0;
        proot = '0;
        prad  = r2q_pkg::QP_W'(quo_r[DN-1]);
      end else begin
        prem  = srem_r[j-1];
        proot = root_r[j-1];
        prad  = srad_r[j-1];
      end
      r2    = {prem[r2q_pkg::RR_W-3:0], prad[r2q_pkg::QP_W-1 -: 2]};
      trial = r2q_pkg::RR_W'({proot, 2'b01});
      if (r2 >= trial) begin
        srem_nxt[j] = r2 - trial;
        root_nxt[j] = {proot[SN-2:0], 1'b1};
      end else begin
        srem_nxt[j] = r2;
        root_nxt[j] = {proot[SN-2:0], 1'b0};
      end
      srad_nxt[j] = {prad[r2q_pkg::QP_W-3:0], 2'b00};
    end
  end

  // stage registers, all advance together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DN; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= (k == 0) ? len2 : den_r[k-1];
        dneg_r[k] <= (k == 0) ? neg_i : dneg_r[k-1];
      end
      for (int j = 0; j < SN; j++) begin
        srem_r[j] <= srem_nxt[j];
        root_r[j] <= root_nxt[j];
        srad_r[j] <= srad_nxt[j];
        sneg_r[j] <= (j == 0) ? dneg_r[DN-1] : sneg_r[j-1];
      end
    end
  end

  // largest n with (2n-1)^2 not above the quotient
  always_comb begin
    logic [SN:0] t1;
    t1  = {1'b0, root_r[SN-1]} + 1'b1;
    n_o = t1[SN:1];
  end
  assign neg_o = sneg_r[SN-1];

endmodule

// ===== rtl/r2q_back.sv =====
// back end: squares, squared length, four normalising lanes and the output register
// depends on r2q_pkg and r2q_lane
module r2q_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  r2q_pkg::rec_t                    q_rec,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [r2q_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [0:0]                       out_tuser
);

  localparam int NC = r2q_pkg::NUM_COMP;
  localparam int BL = r2q_pkg::BACK_LAT;

  logic                          en;
  logic [BL-1:0]                 vld_r, fb_r;
  logic [r2q_pkg::SQ_W-1:0]      sq0_r [NC];
  logic [r2q_pkg::SQ_W-1:0]      sq1_r [NC];
  logic [r2q_pkg::SQ_W-1:0]      sq2_r [NC];
  logic [NC-1:0]                 neg0_r, neg1_r, neg2_r;
  logic [r2q_pkg::SQ_W:0]        pair_r [2];
  logic [r2q_pkg::LEN_W-1:0]     len2_r;
  logic [r2q_pkg::SQ_N-1:0]      n_w [NC];
  logic [NC-1:0]                 nneg_w;
  logic [r2q_pkg::OUT_W-1:0]     qv [NC];
  logic                          out_vld_r;
  logic [r2q_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                          out_fb_r;

  // pipeline moves whenever the output slot is free or being emptied
  assign en    = !out_vld_r || out_tready;
  assign q_pop = en && q_valid;

  // token and fallback flag travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[BL-2:0], q_valid};
      out_vld_r <= vld_r[BL-1];
    end
  end

  // squares, pair sums and squared length
  always_ff @(posedge clk) begin
    if (en) begin
      fb_r <= {fb_r[BL-2:0], q_rec.fb};
      for (int i = 0; i < NC; i++) begin
        sq0_r[i] <= q_rec.mag[i] * q_rec.mag[i];
        sq1_r[i] <= sq0_r[i];
        sq2_r[i] <= sq1_r[i];
      end
      neg0_r    <= q_rec.neg;
      neg1_r    <= neg0_r;
      neg2_r    <= neg1_r;
      pair_r[0] <= {1'b0, sq0_r[0]} + {1'b0, sq0_r[1]};
      pair_r[1] <= {1'b0, sq0_r[2]} + {1'b0, sq0_r[3]};
      len2_r    <= r2q_pkg::LEN_W'(pair_r[0]) + r2q_pkg::LEN_W'(pair_r[1]);
    end
  end

  // one lane per component
  for (genvar g = 0; g < NC; g++) begin : g_lane
    r2q_lane u_lane (
      .clk   (clk),
      .en    (en),
      .a2    (sq2_r[g]),
      .len2  (len2_r),
      .neg_i (neg2_r[g]),
      .n_o   (n_w[g]),
      .neg_o (nneg_w[g])
    );
  end

  // identity on fallback, otherwise saturate and sign
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      if (fb_r[BL-1]) qv[i] = (i == 0) ? r2q_pkg::IDENT_W : '0;
      else qv[i] = r2q_pkg::sat_out(n_w[i], nneg_w[i]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= r2q_pkg::OUT_TDATA_W'({qv[3], qv[2], qv[1], qv[0]});
      out_fb_r   <= fb_r[BL-1];
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_fb_r;

  a_fb_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[r2q_pkg::OUT_W-1:0] == r2q_pkg::IDENT_W &&
      out_tdata[NC*r2q_pkg::OUT_W-1:r2q_pkg::OUT_W] == '0)
    else $error("fallback result is not the identity quaternion");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline tokens moved during a stall");

  a_result_from_token: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[BL-1]))
    else $error("result appeared without a pipeline token");

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, four-branch method, signed Q2.16 in and out.
//
// Input channel in_*: one transaction carries the nine matrix entries r00..r22.
// Output channel out_*: one transaction carries quat_w..quat_z and, in tuser,
// the fell_back flag (identity quaternion given because the radicand was not
// positive). Every input transaction gives exactly one output transaction, in order.
// Throughput is one transaction per cycle while the receiver takes results. An input
// transaction passes the queue, the squaring and length stages, the per-lane restoring divider
// (2*FRAC_BITS + 3 steps), the square root (FRAC_BITS + 2 steps) and the output register.
// The front classifies each matrix in the cycle it is taken and writes it to a
// four-entry queue; the back pipeline pops that queue and advances only while its
// output register is empty or being taken. When the receiver stalls, the back
// holds, the queue fills and in_tready falls when it is full.
// Reset (rst_n low, synchronous) empties the queue and the pipeline; no other
// state is kept between transactions.
// depends on r2q_pkg, r2q_front, r2q_queue, r2q_lane and r2q_back
module rotation_matrix_to_quaternion (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up, 18 bits each
  input  logic [r2q_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up, 18 bits each
  output logic [r2q_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // fell_back
  output logic [0:0]                       out_tuser
);

  r2q_pkg::rec_t front_rec, back_rec;
  logic          q_full, q_not_empty, q_pop, push;

  // accept while the queue has room
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  r2q_front u_front (
    .in_data (in_tdata),
    .rec     (front_rec)
  );

  r2q_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .rd_rec    (back_rec),
    .not_empty (q_not_empty)
  );

  r2q_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_rec      (back_rec),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
